// ===== src/ipv4_prefix_include_exclude_filter_unit_defines.svh =====
// ----------------------------------------------------------------------------
// ipv4 prefix filter assertion macros
// concurrent checks, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef IPV4_PREFIX_INCLUDE_EXCLUDE_FILTER_UNIT_DEFINES_SVH
`define IPV4_PREFIX_INCLUDE_EXCLUDE_FILTER_UNIT_DEFINES_SVH

`ifndef SYNTH
// condition holds at every edge outside reset
`define IPF_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("ipf assertion failed");
// antecedent implies consequent in the next cycle
`define IPF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ipf assertion failed");
`else
`define IPF_ASSERT_ALWAYS(lbl, clk, rst, cond)
`define IPF_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== src/ipf_pkg.sv =====
// ----------------------------------------------------------------------------
// ipf_pkg
// shared types, codes and prefix match function of the ipv4 prefix filter
// ----------------------------------------------------------------------------
`default_nettype none

package ipf_pkg;

   typedef logic [1:0]  kind_type;
   typedef logic [31:0] addr_type;
   typedef logic [5:0]  plen_type;

   localparam kind_type KIND_ADD_INCL = 2'd0;
   localparam kind_type KIND_ADD_EXCL = 2'd1;
   localparam kind_type KIND_QUERY    = 2'd2;

   localparam addr_type FULL_MASK = 32'hFFFF_FFFF;

   typedef struct packed {
      plen_type len;
      addr_type base;
   } rule_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_end;
   } ctrl_status_type;

   // lengths of 32 and above shift the mask fully in, giving an exact match
   function automatic logic prefix_match(addr_type addr, rule_type rule);
      addr_type mask;
      mask = ~(FULL_MASK >> rule.len);
      return (addr & mask) == (rule.base & mask);
   endfunction

endpackage

`default_nettype wire

// ===== src/ipf_channels.sv =====
// ----------------------------------------------------------------------------
// ipf channels
// valid/ready interfaces for request and response transfers
// ----------------------------------------------------------------------------
`default_nettype none

interface ipf_req_if;
   logic               valid;
   logic               ready;
   ipf_pkg::kind_type  kind;
   ipf_pkg::addr_type  address;
   ipf_pkg::plen_type  mask_len;

   modport source (output valid, output kind, output address, output mask_len,
                   input ready);
   modport sink   (input valid, input kind, input address, input mask_len,
                   output ready);
endinterface

interface ipf_rsp_if;
   logic valid;
   logic ready;
   logic status;
   logic displayed;

   modport source (output valid, output status, output displayed, input ready);
   modport sink   (input valid, input status, input displayed, output ready);
endinterface

`default_nettype wire

// ===== src/ipv4_prefix_include_exclude_filter_unit.sv =====
// ----------------------------------------------------------------------------
// ipv4_prefix_include_exclude_filter_unit
// add: request loaded, empty scan, then finish sets response valid; query:
// scan reads one rule of each list per cycle up to the larger fill count
// one item at a time: next request taken only once finish has run, later
// while a held response blocks finish; taken while one waits
// synchronous reset empties both lists; rule memories are not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_prefix_include_exclude_filter_unit #(
   parameter int RULES_PER_LIST = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   ipf_req_if.sink   req_chan,
   ipf_rsp_if.source rsp_chan
);
   import ipf_pkg::*;

   // command and status between sequencer and datapath
   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // sequencer: owns both handshakes and the response valid flag
   ipf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // datapath: rule memories, fill counts, scan and response payload
   ipf_datapath #(
      .RULES_PER_LIST (RULES_PER_LIST)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_kind          (req_chan.kind),
      .req_address       (req_chan.address),
      .req_mask_len      (req_chan.mask_len),
      .rsp_status        (rsp_chan.status),
      .rsp_displayed     (rsp_chan.displayed)
   );

endmodule

`default_nettype wire

// ===== src/ipf_ctrl.sv =====
// ----------------------------------------------------------------------------
// ipf_ctrl
// sequencer: accept, scan rule memories, finish into response register
// ----------------------------------------------------------------------------
`default_nettype none

module ipf_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output ipf_pkg::ctrl_cmd_type         cmd,
   input  wire ipf_pkg::ctrl_status_type status
);
   import ipf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_end) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== src/ipf_datapath.sv =====
// ----------------------------------------------------------------------------
// ipf_datapath
// rule memories, fill counts, scan pointer, match accumulators, result regs
// ----------------------------------------------------------------------------
`default_nettype none
`include "ipv4_prefix_include_exclude_filter_unit_defines.svh"

module ipf_datapath #(
   parameter int RULES_PER_LIST = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ipf_pkg::ctrl_cmd_type cmd,
   output ipf_pkg::ctrl_status_type   status,
   input  wire ipf_pkg::kind_type     req_kind,
   input  wire ipf_pkg::addr_type     req_address,
   input  wire ipf_pkg::plen_type     req_mask_len,
   output logic                       rsp_status,
   output logic                       rsp_displayed
);
   import ipf_pkg::*;

   localparam int IDX_W = (RULES_PER_LIST > 1) ? $clog2(RULES_PER_LIST) : 1;
   localparam int CNT_W = $clog2(RULES_PER_LIST + 1);
   localparam logic [CNT_W-1:0] RULES_CNT = CNT_W'(RULES_PER_LIST);

   rule_type incl_mem [RULES_PER_LIST];
   rule_type excl_mem [RULES_PER_LIST];
   rule_type incl_rd_ff, excl_rd_ff;

   kind_type         kind_ff;
   addr_type         addr_ff;
   plen_type         plen_ff;
   logic [CNT_W-1:0] incl_used_ff, incl_used_in;
   logic [CNT_W-1:0] excl_used_ff, excl_used_in;
   logic [CNT_W-1:0] ptr_ff, pidx_ff, scan_len;
   logic             pend_ff;
   logic             incl_hit_ff, excl_hit_ff;
   logic             rsp_status_ff, rsp_displayed_ff;

   logic     is_query, incl_full, excl_full, incl_we, excl_we, rd_en;
   rule_type new_rule;

   assign is_query  = (kind_ff == KIND_QUERY);
   assign incl_full = (incl_used_ff == RULES_CNT);
   assign excl_full = (excl_used_ff == RULES_CNT);
   assign incl_we   = cmd.finish && (kind_ff == KIND_ADD_INCL) && !incl_full;
   assign excl_we   = cmd.finish && (kind_ff == KIND_ADD_EXCL) && !excl_full;
   assign new_rule  = '{len: plen_ff, base: addr_ff};

   // scan covers the longer list, nothing for adds
   assign scan_len = !is_query ? '0 :
                     (incl_used_ff > excl_used_ff) ? incl_used_ff : excl_used_ff;
   assign rd_en    = cmd.scan && (ptr_ff < scan_len);
   assign status.scan_end = (ptr_ff == scan_len);

   assign incl_used_in = incl_we ? CNT_W'(incl_used_ff + 1'b1) : incl_used_ff;
   assign excl_used_in = excl_we ? CNT_W'(excl_used_ff + 1'b1) : excl_used_ff;

   always_ff @(posedge clock) begin
      if (incl_we) begin
         incl_mem[incl_used_ff[IDX_W-1:0]] <= new_rule;
      end
      if (excl_we) begin
         excl_mem[excl_used_ff[IDX_W-1:0]] <= new_rule;
      end
      if (rd_en) begin
         incl_rd_ff <= incl_mem[ptr_ff[IDX_W-1:0]];
         excl_rd_ff <= excl_mem[ptr_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         incl_used_ff <= '0;
         excl_used_ff <= '0;
         pend_ff      <= 1'b0;
         ptr_ff       <= '0;
      end else begin
         incl_used_ff <= incl_used_in;
         excl_used_ff <= excl_used_in;
         if (cmd.load) begin
            pend_ff <= 1'b0;
            ptr_ff  <= '0;
         end else begin
            pend_ff <= rd_en;
            if (rd_en) begin
               ptr_ff <= CNT_W'(ptr_ff + 1'b1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff     <= req_kind;
         addr_ff     <= req_address;
         plen_ff     <= req_mask_len;
         incl_hit_ff <= 1'b0;
         excl_hit_ff <= 1'b0;
      end else if (pend_ff) begin
         // entries past a list's fill count are ignored
         if ((pidx_ff < incl_used_ff) && prefix_match(addr_ff, incl_rd_ff)) begin
            incl_hit_ff <= 1'b1;
         end
         if ((pidx_ff < excl_used_ff) && prefix_match(addr_ff, excl_rd_ff)) begin
            excl_hit_ff <= 1'b1;
         end
      end
      if (rd_en) begin
         pidx_ff <= ptr_ff;
      end
      if (cmd.finish) begin
         rsp_status_ff    <= ((kind_ff == KIND_ADD_INCL) && incl_full) ||
                             ((kind_ff == KIND_ADD_EXCL) && excl_full);
         rsp_displayed_ff <= is_query && ((incl_used_ff == '0) || incl_hit_ff) &&
                             !excl_hit_ff;
      end
   end

   assign rsp_status    = rsp_status_ff;
   assign rsp_displayed = rsp_displayed_ff;

   `IPF_ASSERT_ALWAYS(a_incl_bound, clock, reset, incl_used_ff <= RULES_CNT)
   `IPF_ASSERT_ALWAYS(a_excl_bound, clock, reset, excl_used_ff <= RULES_CNT)
   `IPF_ASSERT_NEXT(a_incl_grow, clock, reset, incl_we, incl_used_ff == $past(incl_used_ff) + 1'b1)
   `IPF_ASSERT_NEXT(a_add_not_shown, clock, reset, cmd.finish && !is_query, !rsp_displayed_ff)
   `IPF_ASSERT_NEXT(a_query_ok, clock, reset, cmd.finish && is_query, !rsp_status_ff)

endmodule

`default_nettype wire
